// ===== rtl/ccdw_pkg.sv =====
// ----------------------------------------------------------------------------
// ccdw_pkg
// Shared codes, types and calendar helpers for the calendar clock with
// day watch.
// ----------------------------------------------------------------------------
package ccdw_pkg;

  // Request commands, carried on the input tuser
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_TIME = 2'd1;
  localparam logic [1:0] CMD_DATE = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  // Watch modes
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_COMPARE = 2'd1;
  localparam logic [1:0] MODE_REFRESH = 2'd2;

  // Configuration register indexes
  localparam logic REG_SPAN = 1'b0;
  localparam logic REG_MODE = 1'b1;

  localparam int unsigned CfgWidth = 16;

  // Loaded calendar date after range clamping
  typedef struct packed {
    logic [6:0] century;  // century number plus one, 1..99
    logic [6:0] year;     // 0..99
    logic [3:0] month;    // 1..12
    logic [4:0] day;      // 1..31
  } date_t;

  // Length of a month, leap February when requested
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // Gregorian leap rule on (century - 1) * 100 + year
  function automatic logic is_leap(input logic [6:0] century, input logic [6:0] year);
    logic [6:0] cent_idx;
    cent_idx = century - 7'd1;
    if (year != 7'd0) begin
      return (year[1:0] == 2'd0);
    end
    return (cent_idx[1:0] == 2'd0);
  endfunction

endpackage

// ===== rtl/ccdw_weekday.sv =====
// ----------------------------------------------------------------------------
// ccdw_weekday
// Weekday of a loaded date (1 Monday .. 7 Sunday), Kim Larsen formula
// reduced on century and year digits so every term stays narrow.
// ----------------------------------------------------------------------------
module ccdw_weekday import ccdw_pkg::*; (
  input  date_t      date_i,
  output logic [2:0] weekday_o
);

  logic [3:0] mon_adj;
  logic [6:0] yr_adj;
  logic [6:0] cen_adj;   // (full year + 400) / 100
  logic [3:0] mon_term;  // 3 * (m + 1) / 5
  logic [9:0] sum;
  logic [4:0] fold1;
  logic [3:0] fold2;
  logic [2:0] rem;

  // Treat January and February as months 13 and 14 of the year before
  always_comb begin
    if (date_i.month <= 4'd2) begin
      mon_adj = date_i.month + 4'd12;
      if (date_i.year == 7'd0) begin
        yr_adj  = 7'd99;
        cen_adj = date_i.century + 7'd2;
      end else begin
        yr_adj  = date_i.year - 7'd1;
        cen_adj = date_i.century + 7'd3;
      end
    end else begin
      mon_adj = date_i.month;
      yr_adj  = date_i.year;
      cen_adj = date_i.century + 7'd3;
    end
  end

  always_comb begin
    unique case (mon_adj)
      4'd3:           mon_term = 4'd2;
      4'd4, 4'd5:     mon_term = 4'd3;
      4'd6, 4'd7:     mon_term = 4'd4;
      4'd8:           mon_term = 4'd5;
      4'd9, 4'd10:    mon_term = 4'd6;
      4'd11, 4'd12:   mon_term = 4'd7;
      4'd13:          mon_term = 4'd8;
      4'd14:          mon_term = 4'd9;
      default:        mon_term = 4'd0;
    endcase
  end

  // 124 * C folds to 5 * C modulo 7
  always_comb begin
    sum = 10'(date_i.day) + 10'd1 + {5'd0, mon_adj, 1'b0} + 10'(mon_term)
        + 10'(cen_adj) * 10'd5 + 10'(yr_adj) + 10'(yr_adj[6:2]) + 10'(cen_adj[6:2]);
    // 8 is 1 modulo 7: add octal digits
    fold1 = 5'(sum[2:0]) + 5'(sum[5:3]) + 5'(sum[8:6]) + 5'(sum[9]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
    rem   = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
    weekday_o = (rem == 3'd0) ? 3'd7 : rem;
  end

endmodule

// ===== rtl/calendar_clock_with_day_watch.sv =====
// ----------------------------------------------------------------------------
// calendar_clock_with_day_watch
// Calendar clock stepped by millisecond timestamps, with a day watch flag.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle, returns one result per request in the
// cycle after acceptance through a result register; a new request is taken
// while the previous result waits as long as the downstream side takes it in
// the same cycle. The request tuser carries the command: a tick advances the
// clock by one second once TICKS_PER_SECOND milliseconds have passed since
// the last second mark (counted modulo 2^32), a time load sets hour, minute
// and second, a date load sets century, year, month and day and derives the
// weekday. Loaded values saturate into range. Each result shows the clock
// after its request and the watch flag, high in compare mode with a nonzero
// span when roughly 30 days per month plus days since the base date reach it.
// Writing the span recaptures the base date; configure only while idle. The
// deepest path is the weekday derivation on a date load.
// ----------------------------------------------------------------------------
module calendar_clock_with_day_watch import ccdw_pkg::*; #(
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  // request side
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // ms_now[31:0], set_hour[36:32], set_minute[42:37], set_second[48:43],
  // set_century[55:49], set_year[62:56], set_month[66:63], set_day[71:67]
  input  logic [71:0]         s_axis_tdata_i,
  // cmd[1:0]
  input  logic [1:0]          s_axis_tuser_i,
  // result side
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // cur_second[5:0], cur_minute[11:6], cur_hour[16:12], cur_day[21:17],
  // cur_weekday[24:22], cur_month[28:25], cur_year[35:29],
  // cur_century[42:36], watch_reset[43], zero[47:44]
  output logic [47:0]         m_axis_tdata_o
);

  // Request fields
  logic [1:0]  cmd;
  logic [31:0] ms_now;
  logic [4:0]  set_hour;
  logic [5:0]  set_minute, set_second;
  logic [6:0]  set_century, set_year;
  logic [3:0]  set_month;
  logic [4:0]  set_day;

  assign cmd         = s_axis_tuser_i;
  assign ms_now      = s_axis_tdata_i[31:0];
  assign set_hour    = s_axis_tdata_i[36:32];
  assign set_minute  = s_axis_tdata_i[42:37];
  assign set_second  = s_axis_tdata_i[48:43];
  assign set_century = s_axis_tdata_i[55:49];
  assign set_year    = s_axis_tdata_i[62:56];
  assign set_month   = s_axis_tdata_i[66:63];
  assign set_day     = s_axis_tdata_i[71:67];

  // Clock state
  logic [31:0] mark_q, mark_d;
  logic [5:0]  sec_q, sec_d, min_q, min_d;
  logic [4:0]  hour_q, hour_d, day_q, day_d;
  logic [2:0]  wday_q, wday_d;
  logic [3:0]  mon_q, mon_d;
  logic [6:0]  year_q, year_d, cen_q, cen_d;
  logic [4:0]  base_day_q;
  logic [3:0]  base_mon_q;
  logic [CfgWidth-1:0] span_q;
  logic [1:0]  mode_q;

  // Result register
  logic        out_valid_q;
  logic [47:0] out_data_q;

  logic        s_acc;
  logic        tick_due;
  logic [31:0] elapsed;
  logic [5:0]  day_inc;
  logic [4:0]  dim;
  date_t       load_date;
  logic [2:0]  load_wday;
  logic        flag;
  logic [3:0]  months;
  logic [8:0]  est_pos;
  logic [16:0] est_need;

  // Accept when the result register is empty or being drained
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  assign elapsed  = ms_now - mark_q;
  assign tick_due = (elapsed >= 32'(TICKS_PER_SECOND));
  assign day_inc  = {1'b0, day_q} + 6'd1;
  assign dim      = month_days(mon_q, is_leap(cen_q, year_q));

  // Clamp the loaded date into range
  always_comb begin
    load_date.century = (set_century == 7'd0) ? 7'd1 :
                        (set_century > 7'd99) ? 7'd99 : set_century;
    load_date.year    = (set_year > 7'd99) ? 7'd99 : set_year;
    load_date.month   = (set_month == 4'd0) ? 4'd1 :
                        (set_month > 4'd12) ? 4'd12 : set_month;
    load_date.day     = (set_day == 5'd0) ? 5'd1 : set_day;
  end

  ccdw_weekday u_weekday (
    .date_i   (load_date),
    .weekday_o(load_wday)
  );

  // Next clock state for the current request
  always_comb begin
    mark_d = mark_q;
    sec_d  = sec_q;
    min_d  = min_q;
    hour_d = hour_q;
    day_d  = day_q;
    wday_d = wday_q;
    mon_d  = mon_q;
    year_d = year_q;
    cen_d  = cen_q;
    unique case (cmd)
      CMD_TICK: begin
        if (tick_due) begin
          mark_d = ms_now;
          // ripple the carry from seconds up to the century
          if (sec_q < 6'd59) begin
            sec_d = sec_q + 6'd1;
          end else begin
            sec_d = 6'd0;
            if (min_q < 6'd59) begin
              min_d = min_q + 6'd1;
            end else begin
              min_d = 6'd0;
              if (hour_q < 5'd23) begin
                hour_d = hour_q + 5'd1;
              end else begin
                hour_d = 5'd0;
                wday_d = (wday_q >= 3'd7) ? 3'd1 : wday_q + 3'd1;
                if (day_inc <= {1'b0, dim}) begin
                  day_d = day_inc[4:0];
                end else begin
                  day_d = 5'd1;
                  if (mon_q < 4'd12) begin
                    mon_d = mon_q + 4'd1;
                  end else begin
                    mon_d = 4'd1;
                    if (year_q < 7'd99) begin
                      year_d = year_q + 7'd1;
                    end else begin
                      year_d = 7'd0;
                      if (cen_q < 7'd99) begin
                        cen_d = cen_q + 7'd1;
                      end
                    end
                  end
                end
              end
            end
          end
        end
      end
      CMD_TIME: begin
        hour_d = (set_hour > 5'd23) ? 5'd23 : set_hour;
        min_d  = (set_minute > 6'd59) ? 6'd59 : set_minute;
        sec_d  = (set_second > 6'd59) ? 6'd59 : set_second;
      end
      CMD_DATE: begin
        cen_d  = load_date.century;
        year_d = load_date.year;
        mon_d  = load_date.month;
        day_d  = load_date.day;
        wday_d = load_wday;
      end
      CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Day watch: months * 30 + day - base_day >= span, checked without sign
  always_comb begin
    months   = (mon_d < base_mon_q) ? (mon_d + 4'd12 - base_mon_q) : (mon_d - base_mon_q);
    est_pos  = 9'(months) * 9'd30 + 9'(day_d);
    est_need = 17'(span_q) + 17'(base_day_q);
    flag     = (mode_q == MODE_COMPARE) && (span_q != '0) && (17'(est_pos) >= est_need);
  end

  // Clock state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= '0;
      sec_q  <= '0;
      min_q  <= '0;
      hour_q <= '0;
      day_q  <= 5'd1;
      wday_q <= 3'd6;
      mon_q  <= 4'd1;
      year_q <= '0;
      cen_q  <= 7'd21;
    end else if (s_acc) begin
      mark_q <= mark_d;
      sec_q  <= sec_d;
      min_q  <= min_d;
      hour_q <= hour_d;
      day_q  <= day_d;
      wday_q <= wday_d;
      mon_q  <= mon_d;
      year_q <= year_d;
      cen_q  <= cen_d;
    end
  end

  // Configuration and base date
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q     <= '0;
      mode_q     <= MODE_OFF;
      base_day_q <= 5'd1;
      base_mon_q <= 4'd1;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SPAN: begin
            span_q     <= cfg_wdata_i;
            base_day_q <= day_q;
            base_mon_q <= mon_q;
          end
          REG_MODE: mode_q <= cfg_wdata_i[1:0];
          default: begin
          end
        endcase
      end else if (s_acc && mode_q == MODE_REFRESH) begin
        // refresh the base date from the state after this request
        base_day_q <= day_d;
        base_mon_q <= mon_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      out_data_q <= {4'd0, flag, cen_d, year_d, mon_d, wday_d, day_d, hour_d, min_d, sec_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Checks
  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q <= 6'd59 && min_q <= 6'd59 && hour_q <= 5'd23 && day_q != 5'd0 &&
    mon_q != 4'd0 && mon_q <= 4'd12 && cen_q != 7'd0 && cen_q <= 7'd99 && year_q <= 7'd99)
    else $error("clock state out of range");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> m_axis_tvalid_o && m_axis_tdata_o[5:0] == sec_q &&
              m_axis_tdata_o[28:25] == mon_q)
    else $error("result does not match updated state");

  a_no_early_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && cmd == CMD_TICK && !tick_due |=> sec_q == $past(sec_q) && mark_q == $past(mark_q))
    else $error("clock advanced before a full second");

  a_flag_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && flag |-> mode_q == MODE_COMPARE && span_q != '0)
    else $error("watch flag outside compare mode");

  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wday_q != 3'd0)
    else $error("weekday zero");

endmodule
